// ----- hw/rtl/hhp_pkg.sv -----
`timescale 1ns / 1ps

package hhp_pkg;

    localparam int BYTE_BITS  = 8;
    localparam int KIND_BITS  = 3;
    localparam int LIMIT_BITS = 12;
    localparam int VALUE_BITS = 13;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 12'd255;

    localparam logic [BYTE_BITS-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_BITS-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_BITS-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_BITS-1:0] CH_SPACE = 8'h20;

    typedef enum logic [3:0] {
        ST_LINE_START = 4'd0,
        ST_KEY        = 4'd1,
        ST_COLON      = 4'd2,
        ST_SPACE      = 4'd3,
        ST_VALUE      = 4'd4,
        ST_CR         = 4'd5,
        ST_LF         = 4'd6,
        ST_END_CR     = 4'd7,
        ST_DONE       = 4'd8
    } parse_state_t;

    typedef enum logic [KIND_BITS-1:0] {
        K_DELIM   = 3'd0,
        K_KEY     = 3'd1,
        K_VALUE   = 3'd2,
        K_LINE    = 3'd3,
        K_HEADERS = 3'd4,
        K_ERROR   = 3'd5,
        K_BODY    = 3'd6
    } byte_kind_t;

endpackage

// ----- hw/rtl/hhp_in_if.sv -----
`timescale 1ns / 1ps

interface hhp_in_if
    import hhp_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [BYTE_BITS-1:0] data_byte;
    logic                 new_request;

    modport source (output valid, output data_byte, output new_request, input ready);
    modport sink   (input valid, input data_byte, input new_request, output ready);
endinterface

// ----- hw/rtl/hhp_out_if.sv -----
`timescale 1ns / 1ps

interface hhp_out_if
    import hhp_pkg::*;
#(
    parameter int COUNT_BITS = 12
) ();
    logic                  valid;
    logic                  ready;
    logic [BYTE_BITS-1:0]  out_byte;
    logic [KIND_BITS-1:0]  byte_kind;
    logic [COUNT_BITS-1:0] key_length;
    logic [VALUE_BITS-1:0] value_length;

    modport source (output valid, output out_byte, output byte_kind, output key_length,
                    output value_length, input ready);
    modport sink   (input valid, input out_byte, input byte_kind, input key_length,
                    input value_length, output ready);
endinterface

// ----- hw/rtl/hhp_cfg_if.sv -----
`timescale 1ns / 1ps

interface hhp_cfg_if
    import hhp_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [LIMIT_BITS-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/http_header_byte_parser_top.sv -----
`timescale 1ns / 1ps
// A byte is held in the input reg and then in the result reg; its result beat is offered on tx
//   once it lands in the result reg.
// Throughput: one byte per cycle while tx is ready; rx stays ready while the result reg drains.
// Parser state advances once per byte as it moves from the input reg into the result reg.
// Reset (rst_n low, async): state to line start, counts and error cleared, limit back to 255,
//   both pipeline stages emptied. No clearing pass; the block is ready once reset is released.

module http_header_byte_parser_top
    import hhp_pkg::*;
#(
    parameter int COUNT_BITS = 12
) (
    input  logic      clk,
    input  logic      rst_n,
    hhp_in_if.sink    rx,
    hhp_out_if.source tx,
    hhp_cfg_if.sink   cfg
);

    localparam logic [COUNT_BITS-1:0] KEY_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] KEY_ONE = {{(COUNT_BITS-1){1'b0}}, 1'b1};
    localparam logic [VALUE_BITS-1:0] VAL_ONE = {{(VALUE_BITS-1){1'b0}}, 1'b1};

    // ---------------------------------------------------------------
    // Config: single limit register, always ready.
    // ---------------------------------------------------------------
    logic [LIMIT_BITS-1:0] limit_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg.valid)
        begin
            limit_reg <= cfg.data;
        end
    end

    // ---------------------------------------------------------------
    // Input stage: holds one beat until the result reg can take it.
    // ---------------------------------------------------------------
    logic                 s1_valid_reg;
    logic [BYTE_BITS-1:0] s1_byte_reg;
    logic                 s1_new_reg;
    logic                 out_valid_reg;
    logic                 adv;

    // adv: the beat in the input stage is parsed and lands in the result reg
    assign adv      = s1_valid_reg && (!out_valid_reg || tx.ready);
    assign rx.ready = !s1_valid_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            s1_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            s1_byte_reg <= rx.data_byte;
            s1_new_reg  <= rx.new_request;
        end
    end

    // ---------------------------------------------------------------
    // Parser state
    // ---------------------------------------------------------------
    parse_state_t          state_reg, state_next, st_eff;
    logic [COUNT_BITS-1:0] key_cnt_reg, key_cnt_next, kc_eff;
    logic [VALUE_BITS-1:0] val_cnt_reg, val_cnt_next, vc_eff;
    logic                  err_reg, err_next, er_eff;
    byte_kind_t            kind_next;
    logic [COUNT_BITS-1:0] klen_next;
    logic [VALUE_BITS-1:0] vlen_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LINE_START;
            key_cnt_reg <= '0;
            val_cnt_reg <= '0;
            err_reg     <= 1'b0;
        end
        else if (adv)
        begin
            state_reg   <= state_next;
            key_cnt_reg <= key_cnt_next;
            val_cnt_reg <= val_cnt_next;
            err_reg     <= err_next;
        end
    end

    always_comb
    begin
        // new_request restarts the parser before this byte is looked at
        st_eff = s1_new_reg ? ST_LINE_START : state_reg;
        kc_eff = s1_new_reg ? '0 : key_cnt_reg;
        vc_eff = s1_new_reg ? '0 : val_cnt_reg;
        er_eff = s1_new_reg ? 1'b0 : err_reg;

        state_next   = st_eff;
        key_cnt_next = kc_eff;
        val_cnt_next = vc_eff;
        err_next     = er_eff;
        kind_next    = K_DELIM;
        klen_next    = '0;
        vlen_next    = '0;

        if (!er_eff)
        begin
            case (st_eff)
                ST_LINE_START:
                begin
                    // leading CR/LF is skipped
                    if (s1_byte_reg != CH_CR && s1_byte_reg != CH_LF)
                    begin
                        kind_next    = K_KEY;
                        key_cnt_next = KEY_ONE;
                        state_next   = ST_KEY;
                    end
                end
                ST_KEY:
                begin
                    if (s1_byte_reg == CH_COLON)
                    begin
                        state_next = ST_COLON;
                    end
                    else if (s1_byte_reg == CH_CR || s1_byte_reg == CH_LF)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        kind_next = K_KEY;
                        if (kc_eff != KEY_MAX)
                        begin
                            key_cnt_next = kc_eff + KEY_ONE;
                        end
                    end
                end
                ST_COLON:
                begin
                    if (s1_byte_reg == CH_SPACE)
                    begin
                        state_next = ST_SPACE;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                ST_SPACE:
                begin
                    // first value byte, whatever it is
                    kind_next    = K_VALUE;
                    val_cnt_next = VAL_ONE;
                    state_next   = ST_VALUE;
                end
                ST_VALUE:
                begin
                    if (s1_byte_reg == CH_CR)
                    begin
                        state_next = ST_CR;
                    end
                    else if (vc_eff > {1'b0, limit_reg})
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        kind_next    = K_VALUE;
                        val_cnt_next = vc_eff + VAL_ONE;
                    end
                end
                ST_CR:
                begin
                    if (s1_byte_reg == CH_LF)
                    begin
                        kind_next  = K_LINE;
                        klen_next  = kc_eff;
                        vlen_next  = vc_eff;
                        state_next = ST_LF;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                ST_LF:
                begin
                    if (s1_byte_reg == CH_CR)
                    begin
                        state_next = ST_END_CR;
                    end
                    else
                    begin
                        kind_next    = K_KEY;
                        key_cnt_next = KEY_ONE;
                        state_next   = ST_KEY;
                    end
                end
                ST_END_CR:
                begin
                    if (s1_byte_reg == CH_LF)
                    begin
                        kind_next  = K_HEADERS;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                ST_DONE:
                begin
                    kind_next = K_BODY;
                end
                default:
                begin
                    err_next = 1'b1;
                end
            endcase
        end

        // sticky error overrides the kind and the lengths
        if (err_next)
        begin
            kind_next = K_ERROR;
            klen_next = '0;
            vlen_next = '0;
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    logic [BYTE_BITS-1:0]  byte_reg;
    byte_kind_t            kind_reg;
    logic [COUNT_BITS-1:0] klen_reg;
    logic [VALUE_BITS-1:0] vlen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (tx.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            byte_reg <= s1_byte_reg;
            kind_reg <= kind_next;
            klen_reg <= klen_next;
            vlen_reg <= vlen_next;
        end
    end

    assign tx.valid        = out_valid_reg;
    assign tx.out_byte     = byte_reg;
    assign tx.byte_kind    = kind_reg;
    assign tx.key_length   = klen_reg;
    assign tx.value_length = vlen_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // error stays set until a beat with new_request is parsed
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg && !(adv && s1_new_reg)) |=> err_reg)
        else $error("error flag dropped without new request");

    // the kind of each parsed beat agrees with the error flag it leaves behind
    a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> ((kind_reg == K_ERROR) == err_reg))
        else $error("error kind and error flag disagree");

    // lengths are only nonzero on a line-done beat
    a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg != K_LINE) |-> (klen_reg == '0 && vlen_reg == '0))
        else $error("length reported outside line-done beat");

    // body bytes only once the headers are done
    a_body_state: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && kind_next == K_BODY) |-> (st_eff == ST_DONE))
        else $error("body byte before end of headers");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import hhp_pkg::*;

    localparam int CNT_BITS     = 12;
    // No beat is accepted on any channel for this many cycles: the run is hung.
    localparam int STALL_LIMIT  = 5000;
    // Each $error is one line; past this many, mismatches are only counted.
    localparam int REPORT_LIMIT = 60;

    // One classified byte as the parser should report it.
    typedef struct {
        logic [BYTE_BITS-1:0]  out_byte;
        byte_kind_t            kind;
        logic [CNT_BITS-1:0]   key_len;
        logic [VALUE_BITS-1:0] val_len;
    } hdr_result_t;

    logic clk = 1'b0;
    logic rst_n;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    hhp_in_if                              rx();
    hhp_out_if #(.COUNT_BITS(CNT_BITS))    tx();
    hhp_cfg_if                             cfg();

    http_header_byte_parser_top #(
        .COUNT_BITS(CNT_BITS)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx.sink),
        .tx    (tx.source),
        .cfg   (cfg.sink)
    );

    // ------------------------------------------------------------------
    // Parser model: its own copy of the state and of the value limit.
    // Advanced once per accepted input beat, in acceptance order.
    // ------------------------------------------------------------------
    parse_state_t          parse_st;
    logic [CNT_BITS-1:0]   key_cnt;
    logic [VALUE_BITS-1:0] val_cnt;
    logic                  err_seen;
    logic [LIMIT_BITS-1:0] len_limit;

    hdr_result_t classified_q[$];
    hdr_result_t exp_beat;
    int          mismatch_count = 0;

    function automatic hdr_result_t classify_byte(input logic [BYTE_BITS-1:0] b,
                                                  input logic nr);
        hdr_result_t r;
        r.out_byte = b;
        r.kind     = K_DELIM;
        r.key_len  = '0;
        r.val_len  = '0;
        // new_request restarts the request before the byte is looked at
        if (nr)
        begin
            parse_st = ST_LINE_START;
            key_cnt  = '0;
            val_cnt  = '0;
            err_seen = 1'b0;
        end
        if (err_seen)
        begin
            r.kind = K_ERROR;
        end
        else
        begin
            case (parse_st)
                ST_LINE_START:
                begin
                    // leading CR/LF is skipped; anything else, colon too, opens a key
                    if (b == CH_CR || b == CH_LF)
                        r.kind = K_DELIM;
                    else
                    begin
                        r.kind   = K_KEY;
                        key_cnt  = CNT_BITS'(1);
                        parse_st = ST_KEY;
                    end
                end
                ST_KEY:
                begin
                    if (b == CH_COLON)
                    begin
                        r.kind   = K_DELIM;
                        parse_st = ST_COLON;
                    end
                    else if (b == CH_CR || b == CH_LF)
                        err_seen = 1'b1;
                    else
                    begin
                        r.kind = K_KEY;
                        if (key_cnt != '1)
                            key_cnt = key_cnt + 1'b1;
                    end
                end
                ST_COLON:
                begin
                    if (b == CH_SPACE)
                    begin
                        r.kind   = K_DELIM;
                        parse_st = ST_SPACE;
                    end
                    else
                        err_seen = 1'b1;
                end
                ST_SPACE:
                begin
                    // first value byte, whatever it is
                    r.kind   = K_VALUE;
                    val_cnt  = VALUE_BITS'(1);
                    parse_st = ST_VALUE;
                end
                ST_VALUE:
                begin
                    if (b == CH_CR)
                    begin
                        r.kind   = K_DELIM;
                        parse_st = ST_CR;
                    end
                    else if (val_cnt > len_limit)
                        err_seen = 1'b1;
                    else
                    begin
                        r.kind  = K_VALUE;
                        val_cnt = val_cnt + 1'b1;
                    end
                end
                ST_CR:
                begin
                    if (b == CH_LF)
                    begin
                        r.kind    = K_LINE;
                        r.key_len = key_cnt;
                        r.val_len = val_cnt;
                        parse_st  = ST_LF;
                    end
                    else
                        err_seen = 1'b1;
                end
                ST_LF:
                begin
                    // a bare LF here opens the next key
                    if (b == CH_CR)
                    begin
                        r.kind   = K_DELIM;
                        parse_st = ST_END_CR;
                    end
                    else
                    begin
                        r.kind   = K_KEY;
                        key_cnt  = CNT_BITS'(1);
                        parse_st = ST_KEY;
                    end
                end
                ST_END_CR:
                begin
                    if (b == CH_LF)
                    begin
                        r.kind   = K_HEADERS;
                        parse_st = ST_DONE;
                    end
                    else
                        err_seen = 1'b1;
                end
                ST_DONE:
                    r.kind = K_BODY;
                default:
                    err_seen = 1'b1;
            endcase
            if (err_seen)
                r.kind = K_ERROR;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every accepted result beat against the oldest
    // expectation. Sampled at the rising edge.
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input int unsigned exp_v,
                                        input int unsigned act_v);
        if (exp_v != act_v)
        begin
            if (mismatch_count < REPORT_LIMIT)
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && tx.valid && tx.ready)
        begin
            if (classified_q.size() == 0)
            begin
                if (mismatch_count < REPORT_LIMIT)
                    $error("result beat with nothing expected: out_byte %0d", tx.out_byte);
                mismatch_count++;
            end
            else
            begin
                exp_beat = classified_q.pop_front();
                check_field("out_byte", exp_beat.out_byte, tx.out_byte);
                check_field("byte_kind", exp_beat.kind, tx.byte_kind);
                check_field("key_length", exp_beat.key_len, tx.key_length);
                check_field("value_length", exp_beat.val_len, tx.value_length);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: counts cycles in which no beat moves on any channel.
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((rx.valid && rx.ready) || (tx.valid && tx.ready) || (cfg.valid && cfg.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                         quiet_cycles, classified_q.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side back-pressure. The stall mode is redrawn at random
    // times: always ready, coin flip, fixed 3-of-4 pattern, mostly stalled.
    // A test may request a long hold-off through hold_len; the count runs
    // here, one per cycle.
    // ------------------------------------------------------------------
    int stall_mode = 0;
    int mode_left  = 0;
    int hold_len   = 0;
    int hold_cnt   = 0;
    int pat_cnt    = 0;

    always @(negedge clk)
    begin
        if (hold_len != 0)
        begin
            hold_cnt = hold_len;
            hold_len = 0;
        end
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(16, 128);
        end
        else
            mode_left--;
        pat_cnt++;
        if (hold_cnt != 0)
        begin
            hold_cnt--;
            tx.ready <= 1'b0;
        end
        else
        begin
            case (stall_mode)
                0:       tx.ready <= 1'b1;
                1:       tx.ready <= 1'($urandom_range(0, 1));
                2:       tx.ready <= (pat_cnt % 4) != 3;
                default: tx.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Byte sender. Works in bursts of random length with random gaps in
    // between; valid stays high across back-to-back beats of a burst.
    // ------------------------------------------------------------------
    int burst_left = 0;
    bit no_gaps    = 1'b0;

    task automatic send_beat(input logic [BYTE_BITS-1:0] b, input logic nr);
        int idle_cycles;
        idle_cycles = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
                idle_cycles = $urandom_range(1, 6);
        end
        if (no_gaps)
            idle_cycles = 0;
        if (idle_cycles > 0)
        begin
            @(negedge clk);
            rx.valid = 1'b0;
            repeat (idle_cycles - 1) @(negedge clk);
        end
        @(negedge clk);
        rx.valid       = 1'b1;
        rx.data_byte   = b;
        rx.new_request = nr;
        do
            @(posedge clk);
        while (!rx.ready);
        classified_q.push_back(classify_byte(b, nr));
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic send_str(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_beat(s[i], 1'b0);
    endtask

    // Stop offering bytes and let every expected result drain, plus the
    // two-stage pipeline latency with some margin.
    task automatic wait_idle();
        @(negedge clk);
        rx.valid   = 1'b0;
        burst_left = 0;
        while (classified_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_BITS-1:0] v);
        wait_idle();
        @(negedge clk);
        cfg.valid = 1'b1;
        cfg.data  = v;
        do
            @(posedge clk);
        while (!cfg.ready);
        len_limit = v;
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    function automatic logic [BYTE_BITS-1:0] pick_key_byte();
        logic [BYTE_BITS-1:0] b;
        do
            b = BYTE_BITS'($urandom_range(0, 255));
        while (b == CH_COLON || b == CH_CR || b == CH_LF);
        return b;
    endfunction

    function automatic logic [BYTE_BITS-1:0] pick_value_byte();
        logic [BYTE_BITS-1:0] b;
        do
            b = BYTE_BITS'($urandom_range(0, 255));
        while (b == CH_CR);
        return b;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked bytes at the reset limit: skipped leading CR/LF, colon as
    // first key byte, CR as first value byte, LF opening a key, blank line,
    // body, and sticky errors from CR in a key, no space, CR without LF.
    task automatic test_directed();
        send_beat(CH_CR, 1'b1);
        send_beat(CH_LF, 1'b0);
        send_beat(CH_COLON, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_str(": ");
        send_beat(CH_CR, 1'b0);
        send_str("v");
        send_beat(CH_CR, 1'b0);
        send_beat(CH_LF, 1'b0);
        send_beat(CH_LF, 1'b0);
        send_str(": ");
        send_beat(8'h00, 1'b0);
        send_beat(CH_CR, 1'b0);
        send_beat(CH_LF, 1'b0);
        send_beat(CH_CR, 1'b0);
        send_beat(CH_LF, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        // CR inside a key, then the error sticks
        send_beat("A", 1'b1);
        send_beat(CH_CR, 1'b0);
        send_str("B");
        // no space after the colon
        send_beat("A", 1'b1);
        send_str(":x");
        // CR not followed by LF
        send_beat("A", 1'b1);
        send_str(": b");
        send_beat(CH_CR, 1'b0);
        send_str("Z");
    endtask

    // Limit of zero: the second non-CR value byte already fails; at a limit of one, two pass.
    task automatic test_limit_zero();
        write_limit('0);
        send_beat("K", 1'b1);
        send_str(": ab");
        send_beat("K", 1'b1);
        send_str(": a");
        send_beat(CH_CR, 1'b0);
        send_beat(CH_LF, 1'b0);
        write_limit(12'd1);
        send_beat("K", 1'b1);
        send_str(": ab");
        send_beat(CH_CR, 1'b0);
        send_beat(CH_LF, 1'b0);
    endtask

    // Longer fields: a long line at the top limit, then a value that runs
    // past a mid-size limit and fails on its last byte.
    task automatic test_long_fields();
        int i;
        write_limit(12'hFFF);
        send_beat("k", 1'b1);
        for (i = 0; i < 47; i++)
            send_beat(pick_key_byte(), 1'b0);
        send_str(": ");
        send_beat(BYTE_BITS'($urandom_range(0, 255)), 1'b0);
        for (i = 1; i < 48; i++)
            send_beat(pick_value_byte(), 1'b0);
        send_beat(CH_CR, 1'b0);
        send_beat(CH_LF, 1'b0);
        write_limit(12'd40);
        send_str("k: ");
        for (i = 0; i < 42; i++)
            send_beat(pick_value_byte(), 1'b0);
        send_beat(CH_CR, 1'b0);
        write_limit(LIMIT_RESET);
    endtask

    // Receiver holds off for a long stretch while bytes keep coming, so the
    // pipeline fills and the input side has to stall.
    task automatic test_backpressure();
        int i;
        wait_idle();
        no_gaps  = 1'b1;
        hold_len = 150;
        send_beat("H", 1'b1);
        send_str("ost: ");
        for (i = 0; i < 30; i++)
            send_beat(pick_value_byte(), 1'b0);
        send_beat(CH_CR, 1'b0);
        send_beat(CH_LF, 1'b0);
        no_gaps = 1'b0;
    endtask

    // One mostly well-formed request: optional leading CR/LF, a few lines,
    // usually a blank line and a little body. Now and then one byte is
    // corrupted or a new_request lands mid-stream.
    task automatic send_request(input int vmax, output int sent);
        logic [BYTE_BITS-1:0] req[$];
        int nlines;
        int klen;
        int vlen;
        int i;
        int j;
        int spot;
        repeat ($urandom_range(0, 2))
            req.push_back(($urandom_range(0, 1) != 0) ? CH_CR : CH_LF);
        nlines = $urandom_range(1, 4);
        for (i = 0; i < nlines; i++)
        begin
            klen = $urandom_range(1, 6);
            for (j = 0; j < klen; j++)
                req.push_back(pick_key_byte());
            req.push_back(CH_COLON);
            req.push_back(CH_SPACE);
            vlen = $urandom_range(1, vmax);
            req.push_back(BYTE_BITS'($urandom_range(0, 255)));
            for (j = 1; j < vlen; j++)
                req.push_back(pick_value_byte());
            req.push_back(CH_CR);
            req.push_back(CH_LF);
        end
        if ($urandom_range(0, 4) != 0)
        begin
            req.push_back(CH_CR);
            req.push_back(CH_LF);
            repeat ($urandom_range(0, 3))
                req.push_back(BYTE_BITS'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 3) == 0)
        begin
            spot = $urandom_range(0, req.size() - 1);
            case ($urandom_range(0, 4))
                0:       req[spot] = CH_CR;
                1:       req[spot] = CH_LF;
                2:       req[spot] = CH_COLON;
                3:       req[spot] = CH_SPACE;
                default: req[spot] = BYTE_BITS'($urandom_range(0, 255));
            endcase
        end
        for (i = 0; i < req.size(); i++)
            send_beat(req[i], (i == 0) || ($urandom_range(0, 63) == 0));
        sent = req.size();
    endtask

    task automatic test_random();
        int random_beats;
        int phase_beats;
        int sent;
        int lim;
        int vmax;
        int n;
        random_beats = 0;
        while (random_beats < 450)
        begin
            case ($urandom_range(0, 4))
                0:       lim = 0;
                1:       lim = 1;
                2:       lim = $urandom_range(2, 10);
                3:       lim = 4095;
                default: lim = 255;
            endcase
            write_limit(lim[LIMIT_BITS-1:0]);
            vmax = (lim + 2 < 12) ? lim + 2 : 12;
            phase_beats = 0;
            while (phase_beats < 120)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // raw noise, new_request on some of it
                    n = $urandom_range(1, 8);
                    repeat (n)
                        send_beat(BYTE_BITS'($urandom_range(0, 255)),
                                  $urandom_range(0, 3) == 0);
                    sent = n;
                end
                else
                    send_request(vmax, sent);
                phase_beats  += sent;
                random_beats += sent;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        rx.valid       = 1'b0;
        rx.data_byte   = '0;
        rx.new_request = 1'b0;
        cfg.valid      = 1'b0;
        cfg.data       = '0;
        parse_st       = ST_LINE_START;
        key_cnt        = '0;
        val_cnt        = '0;
        err_seen       = 1'b0;
        len_limit      = LIMIT_RESET;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_limit_zero();
        test_long_fields();
        test_backpressure();
        test_random();

        // drain; the watchdog covers results that never show up
        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && classified_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
